// ===== hw/rtl/bblgw_pkg.sv =====
// ----------------------------------------------------------------------------
// bblgw_pkg
// Shared types and constants for the Bayer black level / gain / WB front end.
// ----------------------------------------------------------------------------
package bblgw_pkg;

  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned REG_DATA_W = 32;
  localparam int unsigned REG_ADDR_W = 5;
  localparam int unsigned REG_IDX_W  = 3;
  localparam int unsigned PIX_PORT_W = 16;
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned CFA_W      = 2;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_BLK_OFFSET   = 3'd0,
    REG_DIGITAL_GAIN = 3'd1,
    REG_RED_GAIN     = 3'd2,
    REG_BLUE_GAIN    = 3'd3,
    REG_CFA_PHASE    = 3'd4
  } reg_idx_e;

  typedef enum logic [CFA_W-1:0] {
    COLOR_R  = 2'd0,
    COLOR_GR = 2'd1,
    COLOR_GB = 2'd2,
    COLOR_B  = 2'd3
  } color_e;

endpackage

// ===== hw/rtl/bblgw_gain.sv =====
// ----------------------------------------------------------------------------
// bblgw_gain
// Two-stage gain unit: multiply by unsigned fixed-point gain, then round half
// up, drop fraction bits and saturate to the pixel range.
// ----------------------------------------------------------------------------
module bblgw_gain #(
  parameter int unsigned PIX_W  = 16,
  parameter int unsigned FRAC_W = 12,
  parameter int unsigned SIDE_W = 2
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  logic [PIX_W-1:0]           pix_i,
  input  logic [bblgw_pkg::GAIN_W-1:0] gain_i,
  input  logic [SIDE_W-1:0]          side_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output logic [PIX_W-1:0]           pix_o,
  output logic [SIDE_W-1:0]          side_o
);
  import bblgw_pkg::*;

  localparam int unsigned PROD_W = PIX_W + GAIN_W;
  localparam int unsigned SUM_W  = PROD_W + 1;
  localparam int unsigned SHR_W  = SUM_W - FRAC_W;

  logic              a_v_q;
  logic [PROD_W-1:0] a_prod_q;
  logic [SIDE_W-1:0] a_side_q;
  logic              b_v_q;
  logic [PIX_W-1:0]  b_pix_q;
  logic [SIDE_W-1:0] b_side_q;

  logic              a_adv;
  logic              in_adv;
  logic [SUM_W-1:0]  sum;
  logic [SHR_W-1:0]  shr;
  logic [PIX_W-1:0]  pix_d;

  assign a_adv   = !b_v_q || ready_i;
  assign ready_o = !a_v_q || a_adv;
  assign in_adv  = valid_i && ready_o;

  assign sum   = SUM_W'(a_prod_q) + (SUM_W'(1) << (FRAC_W - 1));
  assign shr   = sum[SUM_W-1:FRAC_W];
  assign pix_d = (|shr[SHR_W-1:PIX_W]) ? {PIX_W{1'b1}} : shr[PIX_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
    end else begin
      if (ready_o) a_v_q <= valid_i;
      if (a_adv)   b_v_q <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv) begin
      a_prod_q <= PROD_W'(pix_i) * PROD_W'(gain_i);
      a_side_q <= side_i;
    end
    if (a_adv && a_v_q) begin
      b_pix_q  <= pix_d;
      b_side_q <= a_side_q;
    end
  end

  assign valid_o = b_v_q;
  assign pix_o   = b_pix_q;
  assign side_o  = b_side_q;

endmodule

// ===== hw/rtl/bayer_black_level_gain_wb.sv =====
// ----------------------------------------------------------------------------
// bayer_black_level_gain_wb
// Raw Bayer front end: black level clamp, digital gain, white balance gain.
// ----------------------------------------------------------------------------
//  Channel   Dir  Contents
//  s_axis    in   tdata: pixel_in[15:0]; tuser: row_odd[0], col_odd[1]
//  m_axis    out  tdata: pixel_out[15:0]
//  apb       in   blk_offset, digital_gain, red_gain, blue_gain, cfa_phase
//
//  One pixel per clock while m_axis accepts; pipeline of a black level stage
//  and two stages per gain unit. Reset clears all valid bits and loads register
//  defaults (unity gains). A stall at m_axis holds every full stage; empty
//  stages keep filling, so no transfer is lost or repeated.
// ----------------------------------------------------------------------------
module bayer_black_level_gain_wb #(
  parameter int unsigned PIXEL_BITS     = 16,
  parameter int unsigned GAIN_FRAC_BITS = 12
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [15:0] pixel_in
  input  logic [bblgw_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // [0] row_odd, [1] col_odd
  input  logic [bblgw_pkg::IN_USER_W-1:0]    s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [15:0] pixel_out
  output logic [bblgw_pkg::PIX_PORT_W-1:0]   m_axis_tdata,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [bblgw_pkg::REG_ADDR_W-1:0]   paddr,
  input  logic [bblgw_pkg::REG_DATA_W-1:0]   pwdata,
  output logic [bblgw_pkg::REG_DATA_W-1:0]   prdata,
  output logic                               pready
);
  import bblgw_pkg::*;

  localparam logic [GAIN_W-1:0] GainUnity = GAIN_W'(1) << GAIN_FRAC_BITS;

  // configuration registers
  logic [PIX_PORT_W-1:0] blk_offset_q;
  logic [GAIN_W-1:0]     digital_gain_q;
  logic [GAIN_W-1:0]     red_gain_q;
  logic [GAIN_W-1:0]     blue_gain_q;
  logic [CFA_W-1:0]      cfa_phase_q;
  logic                  reg_wr;
  reg_idx_e              reg_idx;

  assign pready  = 1'b1;
  assign reg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_e'(paddr[REG_ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_offset_q   <= '0;
      digital_gain_q <= GainUnity;
      red_gain_q     <= GainUnity;
      blue_gain_q    <= GainUnity;
      cfa_phase_q    <= '0;
    end else if (reg_wr) begin
      case (reg_idx)
        REG_BLK_OFFSET:   blk_offset_q   <= pwdata[PIX_PORT_W-1:0];
        REG_DIGITAL_GAIN: digital_gain_q <= pwdata[GAIN_W-1:0];
        REG_RED_GAIN:     red_gain_q     <= pwdata[GAIN_W-1:0];
        REG_BLUE_GAIN:    blue_gain_q    <= pwdata[GAIN_W-1:0];
        REG_CFA_PHASE:    cfa_phase_q    <= pwdata[CFA_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_BLK_OFFSET:   prdata = REG_DATA_W'(blk_offset_q);
      REG_DIGITAL_GAIN: prdata = REG_DATA_W'(digital_gain_q);
      REG_RED_GAIN:     prdata = REG_DATA_W'(red_gain_q);
      REG_BLUE_GAIN:    prdata = REG_DATA_W'(blue_gain_q);
      REG_CFA_PHASE:    prdata = REG_DATA_W'(cfa_phase_q);
      default:          prdata = '0;
    endcase
  end

  // stage 1: black level clamp and site color
  logic                  bl_v_q;
  logic [PIXEL_BITS-1:0] bl_pix_q;
  logic [CFA_W-1:0]      bl_col_q;
  logic [PIX_PORT_W-1:0] pix_in16;
  logic [PIX_PORT_W-1:0] diff16;
  logic                  dg_ready;

  assign pix_in16      = PIX_PORT_W'(s_axis_tdata[PIXEL_BITS-1:0]);
  assign diff16        = (pix_in16 > blk_offset_q) ? (pix_in16 - blk_offset_q) : '0;
  assign s_axis_tready = !bl_v_q || dg_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bl_v_q <= 1'b0;
    end else if (s_axis_tready) begin
      bl_v_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      bl_pix_q <= diff16[PIXEL_BITS-1:0];
      bl_col_q <= cfa_phase_q ^ {s_axis_tuser[0], s_axis_tuser[1]};
    end
  end

  // stages 2-3: digital gain
  logic                  dg_v;
  logic                  wb_ready;
  logic [PIXEL_BITS-1:0] dg_pix;
  logic [CFA_W-1:0]      dg_col;
  logic [GAIN_W-1:0]     wb_gain;
  logic                  wb_v;
  logic [PIXEL_BITS-1:0] wb_pix;

  bblgw_gain #(
    .PIX_W  (PIXEL_BITS),
    .FRAC_W (GAIN_FRAC_BITS),
    .SIDE_W (CFA_W)
  ) u_dgain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (bl_v_q),
    .ready_o (dg_ready),
    .pix_i   (bl_pix_q),
    .gain_i  (digital_gain_q),
    .side_i  (bl_col_q),
    .valid_o (dg_v),
    .ready_i (wb_ready),
    .pix_o   (dg_pix),
    .side_o  (dg_col)
  );

  // green sites use unity gain, which reproduces the pixel exactly
  always_comb begin
    case (color_e'(dg_col))
      COLOR_R: wb_gain = red_gain_q;
      COLOR_B: wb_gain = blue_gain_q;
      default: wb_gain = GainUnity;
    endcase
  end

  // stages 4-5: white balance
  bblgw_gain #(
    .PIX_W  (PIXEL_BITS),
    .FRAC_W (GAIN_FRAC_BITS),
    .SIDE_W (CFA_W)
  ) u_wbgain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dg_v),
    .ready_o (wb_ready),
    .pix_i   (dg_pix),
    .gain_i  (wb_gain),
    .side_i  (dg_col),
    .valid_o (wb_v),
    .ready_i (m_axis_tready),
    .pix_o   (wb_pix),
    .side_o  ()
  );

  assign m_axis_tvalid = wb_v;
  assign m_axis_tdata  = PIX_PORT_W'(wb_pix);

  // checks
  a_out_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tdata >> PIXEL_BITS) == '0))
    else $error("pixel_out above pixel range");

  a_bl_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bl_v_q && !dg_ready) |=> (bl_v_q && $stable(bl_pix_q) && $stable(bl_col_q)))
    else $error("black level stage lost data under stall");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !bl_v_q |-> s_axis_tready)
    else $error("input stalled with empty first stage");

endmodule
